/* rtl/core/dsi_pkg.sv */
`timescale 1ns / 1ps

package dsi_pkg;

  // ASCII codes and the radix
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam int unsigned RADIX   = 10;

  // Largest magnitudes allowed for each sign
  localparam logic [63:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NEG_LIMIT = 64'h8000_0000_0000_0000;

  typedef enum logic [1:0] {
    PH_START  = 2'd0,
    PH_MINUS  = 2'd1,
    PH_DIGITS = 2'd2,
    PH_FAIL   = 2'd3
  } phase_t;

  // One character of the string
  typedef struct packed {
    logic [7:0] char_byte;
    logic       is_last;
  } char_t;

  // One parse result
  typedef struct packed {
    logic               ok;
    logic signed [63:0] parsed_value;
  } result_t;

  // Parser state carried between characters
  typedef struct packed {
    phase_t      phase;
    logic        negative_flag;
    logic [63:0] magnitude_acc;
  } parse_state_t;

endpackage

/* rtl/core/dsi_step.sv */
`timescale 1ns / 1ps

// Next-state and result logic for one character
module dsi_step (
  input  dsi_pkg::char_t        ch,
  input  dsi_pkg::parse_state_t state,
  output dsi_pkg::parse_state_t state_next,
  output dsi_pkg::result_t      res
);

  logic                  is_digit;
  logic                  nonzero_digit;
  logic [7:0]            digit_full;
  logic [3:0]            digit;
  logic [67:0]           scaled;
  logic                  acc_ovf;
  dsi_pkg::parse_state_t upd;

  assign is_digit      = (ch.char_byte >= dsi_pkg::CH_ZERO) &&
                         (ch.char_byte <= dsi_pkg::CH_NINE);
  assign nonzero_digit = (ch.char_byte >= dsi_pkg::CH_ONE) &&
                         (ch.char_byte <= dsi_pkg::CH_NINE);
  assign digit_full    = ch.char_byte - dsi_pkg::CH_ZERO;
  assign digit         = digit_full[3:0];

  // acc * 10 + digit as (acc << 3) + (acc << 1) + digit, with carry room
  assign scaled  = {1'b0, state.magnitude_acc, 3'b000} +
                   {3'b000, state.magnitude_acc, 1'b0} +
                   {64'd0, digit};
  assign acc_ovf = |scaled[67:64];

  // Phase transitions
  always_comb begin
    upd = state;
    unique case (state.phase)
      dsi_pkg::PH_START: begin
        if (ch.char_byte == dsi_pkg::CH_ZERO && ch.is_last) begin
          // lone zero: value 0, sign is always clear at string start
          upd.phase         = dsi_pkg::PH_DIGITS;
          upd.magnitude_acc = '0;
        end else if (ch.char_byte == dsi_pkg::CH_MINUS) begin
          upd.negative_flag = 1'b1;
          upd.phase         = ch.is_last ? dsi_pkg::PH_FAIL : dsi_pkg::PH_MINUS;
        end else if (nonzero_digit) begin
          upd.magnitude_acc = {60'd0, digit};
          upd.phase         = dsi_pkg::PH_DIGITS;
        end else begin
          upd.phase = dsi_pkg::PH_FAIL;
        end
      end
      dsi_pkg::PH_MINUS: begin
        if (nonzero_digit) begin
          upd.magnitude_acc = {60'd0, digit};
          upd.phase         = dsi_pkg::PH_DIGITS;
        end else begin
          upd.phase = dsi_pkg::PH_FAIL;
        end
      end
      dsi_pkg::PH_DIGITS: begin
        if (!is_digit || acc_ovf) begin
          upd.phase = dsi_pkg::PH_FAIL;
        end else begin
          upd.magnitude_acc = scaled[63:0];
        end
      end
      default: begin
        upd.phase = dsi_pkg::PH_FAIL;
      end
    endcase
  end

  // Range check and sign on the final character
  always_comb begin
    res.ok           = 1'b0;
    res.parsed_value = '0;
    if (upd.phase == dsi_pkg::PH_DIGITS) begin
      if (upd.negative_flag) begin
        if (upd.magnitude_acc <= dsi_pkg::NEG_LIMIT) begin
          res.ok           = 1'b1;
          res.parsed_value = $signed(64'd0 - upd.magnitude_acc);
        end
      end else if (upd.magnitude_acc <= dsi_pkg::POS_LIMIT) begin
        res.ok           = 1'b1;
        res.parsed_value = $signed(upd.magnitude_acc);
      end
    end
  end

  // Back to string start after the final character
  always_comb begin
    if (ch.is_last) begin
      state_next.phase         = dsi_pkg::PH_START;
      state_next.negative_flag = 1'b0;
      state_next.magnitude_acc = '0;
    end else begin
      state_next = upd;
    end
  end

endmodule

/* rtl/core/decimal_string_to_int64_parser.sv */
`timescale 1ns / 1ps

// Strict ASCII decimal to signed 64-bit parser.
// Character channel (char_valid / char_stall / char_data): one byte per
// transfer, first character first, is_last set on the final byte.
// Result channel (result_valid / result_stall / result_data): one transfer
// per string, ok and the two's complement value (0 when ok is 0).
// A character waits in the input register; the state update and the range
// check are combinational from there into the result register, so
// result_valid is registered when the final character fires from the
// input register, and the result transfers while result_stall is low.
// Throughput is one character per cycle while char_stall is low; the
// multiply-by-ten-and-add on the 64-bit accumulator is combinational.
// When the receiver stalls, the result register holds; non-final characters
// keep flowing, and a following final character waits in the input
// register, which then stalls the character channel.
// Synchronous reset returns the parser to string start with an empty
// accumulator and no pending result.
module decimal_string_to_int64_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             char_valid,
  output logic             char_stall,
  input  dsi_pkg::char_t   char_data,
  output logic             result_valid,
  input  logic             result_stall,
  output dsi_pkg::result_t result_data
);

  logic                  in_q_valid;
  dsi_pkg::char_t        in_q;
  dsi_pkg::parse_state_t state;
  dsi_pkg::parse_state_t state_next;
  dsi_pkg::result_t      step_res;
  logic                  res_free;
  logic                  fire;

  dsi_step u_step (
    .ch         (in_q),
    .state      (state),
    .state_next (state_next),
    .res        (step_res)
  );

  // A final character needs room in the result register
  assign res_free   = !result_valid || !result_stall;
  assign fire       = in_q_valid && (!in_q.is_last || res_free);
  assign char_stall = in_q_valid && !fire;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!char_stall) begin
      in_q_valid <= char_valid;
    end
    if (!char_stall && char_valid) begin
      in_q <= char_data;
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase         <= dsi_pkg::PH_START;
      state.negative_flag <= 1'b0;
      state.magnitude_acc <= '0;
    end else if (fire) begin
      state <= state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fire && in_q.is_last) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
    if (fire && in_q.is_last) begin
      result_data <= step_res;
    end
  end

  // A finished string leaves the parser at string start
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    fire && in_q.is_last |=> state.phase == dsi_pkg::PH_START &&
                             state.magnitude_acc == '0 && !state.negative_flag)
    else $error("parser state not cleared after final character");

  // Every final character yields a pending result
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    fire && in_q.is_last |=> result_valid)
    else $error("final character produced no result");

  // Input side stalls only behind a blocked result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    char_stall |-> in_q_valid && in_q.is_last && result_valid && result_stall)
    else $error("character channel stalled without a blocked result");

  // A failed result carries zero
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_data.ok |-> result_data.parsed_value == '0)
    else $error("failed parse with non-zero value");

endmodule
